>>> rtl/esc_pkg.sv
`default_nettype none

package esc_pkg;

    typedef enum logic [2:0] {
        CFG_TEMP_CALIB       = 3'd0,
        CFG_PRESS_CALIB_LO   = 3'd1,
        CFG_PRESS_CALIB_MID  = 3'd2,
        CFG_PRESS_CALIB_HI   = 3'd3,
        CFG_HUM_CALIB_A      = 3'd4,
        CFG_HUM_CALIB_B      = 3'd5,
        CFG_FINE_TEMP_OFFSET = 3'd6
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam int DIV_STEPS = 64;

    localparam logic signed [32:0] T_FINE_BASE = 33'sd128000;
    localparam logic signed [31:0] T_ROUND     = 32'sd128;
    localparam logic [20:0]        P_BASE      = 21'd1048576;
    localparam logic [11:0]        P_SCALE     = 12'd3125;
    localparam logic [63:0]        P_ONE47     = 64'h0000_8000_0000_0000;
    localparam logic signed [31:0] H_FINE_BASE = 32'sd76800;
    localparam logic signed [31:0] H_ROUND_A   = 32'sd16384;
    localparam logic signed [31:0] H_BIAS_A    = 32'sd32768;
    localparam logic signed [31:0] H_BIAS_B    = 32'sd2097152;
    localparam logic signed [31:0] H_ROUND_B   = 32'sd8192;
    localparam logic signed [31:0] H_MAX       = 32'sd419430400;

endpackage

`default_nettype wire

>>> rtl/environmental_sensor_compensation.sv
// Temperature, pressure and humidity compensation of one raw sensor reading.
// Input channel: i_in_valid with the three raw fields; a beat is taken when
// i_in_valid is high and o_in_stall is low. Output channel: o_out_valid with
// the five result fields; a beat leaves when o_out_valid is high and
// i_out_stall is low. The calibration registers are written over the cfg
// channel (index, data), which is always ready; write them only while no
// reading is in flight.
// Pipeline: 84 register stages, from the stage that takes a reading to the
// output stage.
// Throughput: one reading per cycle when nothing stalls. The pressure division
// runs one quotient bit per stage over 64 stages and sets the depth.
// Stall: while a result sits in the output stage and i_out_stall is high,
// the whole pipeline holds and o_in_stall is high; nothing is lost.
// Reset: i_rst_n low at a clock edge empties the pipeline and clears all
// calibration registers to zero.
`default_nettype none

module environmental_sensor_compensation (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire  [19:0]                     i_raw_pressure,
    input  wire  [19:0]                     i_raw_temperature,
    input  wire  [15:0]                     i_raw_humidity,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic signed [23:0]              o_temperature_centi,
    output logic [31:0]                     o_pressure_q24_8,
    output logic                            o_pressure_valid,
    output logic [16:0]                     o_humidity_q22_10,
    output logic signed [31:0]              o_fine_temp,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [esc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [esc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int NS      = 84;
    localparam int ST_TF   = 3;
    localparam int ST_TEMP = 4;
    localparam int ST_DIV  = 12;
    localparam int ST_Q    = ST_DIV + esc_pkg::DIV_STEPS + 1;
    localparam int ST_OUT  = NS - 1;
    localparam int DS      = esc_pkg::DIV_STEPS;

    logic [47:0]        r_temp_calib;
    logic [47:0]        r_press_calib_lo;
    logic [47:0]        r_press_calib_mid;
    logic [47:0]        r_press_calib_hi;
    logic [31:0]        r_hum_calib_a;
    logic [31:0]        r_hum_calib_b;
    logic signed [31:0] r_fine_temp_offset;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib       <= '0;
            r_press_calib_lo   <= '0;
            r_press_calib_mid  <= '0;
            r_press_calib_hi   <= '0;
            r_hum_calib_a      <= '0;
            r_hum_calib_b      <= '0;
            r_fine_temp_offset <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (esc_pkg::t_cfg_idx'(i_cfg_index))
                esc_pkg::CFG_TEMP_CALIB:       r_temp_calib       <= i_cfg_data[47:0];
                esc_pkg::CFG_PRESS_CALIB_LO:   r_press_calib_lo   <= i_cfg_data[47:0];
                esc_pkg::CFG_PRESS_CALIB_MID:  r_press_calib_mid  <= i_cfg_data[47:0];
                esc_pkg::CFG_PRESS_CALIB_HI:   r_press_calib_hi   <= i_cfg_data[47:0];
                esc_pkg::CFG_HUM_CALIB_A:      r_hum_calib_a      <= i_cfg_data[31:0];
                esc_pkg::CFG_HUM_CALIB_B:      r_hum_calib_b      <= i_cfg_data[31:0];
                esc_pkg::CFG_FINE_TEMP_OFFSET: r_fine_temp_offset <= $signed(i_cfg_data[31:0]);
                default: ;
            endcase
        end
    end

    logic [15:0]        w_t1;
    logic signed [15:0] w_t2, w_t3;
    logic [15:0]        w_p1;
    logic signed [15:0] w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [7:0]         w_h1, w_h3;
    logic signed [15:0] w_h2;
    logic signed [11:0] w_h4, w_h5;
    logic signed [7:0]  w_h6;

    assign w_t1 = r_temp_calib[15:0];
    assign w_t2 = r_temp_calib[31:16];
    assign w_t3 = r_temp_calib[47:32];
    assign w_p1 = r_press_calib_lo[15:0];
    assign w_p2 = r_press_calib_lo[31:16];
    assign w_p3 = r_press_calib_lo[47:32];
    assign w_p4 = r_press_calib_mid[15:0];
    assign w_p5 = r_press_calib_mid[31:16];
    assign w_p6 = r_press_calib_mid[47:32];
    assign w_p7 = r_press_calib_hi[15:0];
    assign w_p8 = r_press_calib_hi[31:16];
    assign w_p9 = r_press_calib_hi[47:32];
    assign w_h1 = r_hum_calib_a[7:0];
    assign w_h2 = r_hum_calib_a[23:8];
    assign w_h3 = r_hum_calib_a[31:24];
    assign w_h4 = r_hum_calib_b[11:0];
    assign w_h5 = r_hum_calib_b[23:12];
    assign w_h6 = r_hum_calib_b[31:24];

    logic [NS-1:0] r_vld;
    logic          en;

    assign en         = !(r_vld[ST_OUT] && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_in_valid};
        end
    end

    // carried fields
    logic [19:0]        r_rt0;
    logic [19:0]        r_rp [0:8];
    logic [15:0]        r_rh [0:4];
    logic signed [31:0] r_tf [ST_TF:ST_OUT];
    logic [23:0]        r_temp [ST_TEMP:ST_OUT];
    logic [16:0]        r_hum [ST_DIV:ST_OUT];
    logic               r_zero [ST_DIV:ST_OUT-1];

    // temperature
    logic signed [31:0] r_s1_x2, r_s1_dd, r_s2_v1, r_s2_m3;
    logic signed [17:0] w_s1_x;
    logic signed [33:0] w_s1_xp;
    logic signed [16:0] w_s1_d;
    logic signed [33:0] w_s1_dd;
    logic signed [31:0] w_s2_dds;
    logic signed [35:0] w_s2_m;
    logic signed [31:0] w_s4_t5;

    assign w_s1_x   = $signed({1'b0, r_rt0[19:3]}) - $signed({1'b0, w_t1, 1'b0});
    assign w_s1_xp  = w_s1_x * w_t2;
    assign w_s1_d   = $signed({1'b0, r_rt0[19:4]}) - $signed({1'b0, w_t1});
    assign w_s1_dd  = w_s1_d * w_s1_d;
    assign w_s2_dds = r_s1_dd >>> 12;
    assign w_s2_m   = $signed(w_s2_dds[19:0]) * w_t3;
    assign w_s4_t5  = (r_tf[ST_TF] <<< 2) + r_tf[ST_TF] + esc_pkg::T_ROUND;

    // humidity
    logic signed [31:0] w_s4_hv;
    logic signed [31:0] r_s4_hm5, r_s4_hm6, r_s4_hm3;
    logic signed [31:0] w_s5_ha;
    logic signed [31:0] r_ha [5:8];
    logic signed [31:0] r_s5_x6, r_s5_y3, r_s6_hb0, r_s7_hb1, r_s8_hb;
    logic signed [31:0] r_vv [9:11];
    logic signed [31:0] w_s10_s;
    logic signed [31:0] r_s10_sq, r_s11_k;
    logic signed [31:0] w_s12_v;

    assign w_s4_hv  = r_tf[ST_TF] - esc_pkg::H_FINE_BASE;
    assign w_s5_ha  = $signed({2'b0, r_rh[4], 14'b0}) - $signed({w_h4, 20'b0})
                      - r_s4_hm5 + esc_pkg::H_ROUND_A;
    assign w_s10_s  = r_vv[9] >>> 15;
    assign w_s12_v  = r_vv[11] - (r_s11_k >>> 4);

    // pressure
    logic signed [32:0] r_s4_a;
    logic signed [65:0] w_s5_aa;
    logic [63:0]        r_s5_aa;
    logic signed [48:0] r_ap5 [5:7];
    logic signed [48:0] r_ap2 [5:7];
    logic signed [48:0] r_s6_b6l, r_s6_b3l;
    logic signed [31:0] r_s6_b6h, r_s6_b3h;
    logic signed [63:0] r_s7_aap6, r_s7_aap3;
    logic signed [63:0] w_s8_a3s;
    logic [63:0]        r_s8_b, r_s8_a2;
    logic [20:0]        w_s9_pd;
    logic [63:0]        r_s9_x, r_s9_n;
    logic [47:0]        r_s10_xl;
    logic [31:0]        r_s10_xh;
    logic [43:0]        r_s10_nl;
    logic [31:0]        r_s10_nh;
    logic [63:0]        w_s11_sx;
    logic signed [30:0] r_s11_ad;
    logic [63:0]        r_s11_num;

    assign w_s5_aa  = r_s4_a * r_s4_a;
    assign w_s8_a3s = r_s7_aap3 >>> 8;
    assign w_s9_pd  = esc_pkg::P_BASE - {1'b0, r_rp[8]};
    assign w_s11_sx = {16'b0, r_s10_xl} + {r_s10_xh, 32'b0};

    // division, one quotient bit per stage
    logic [63:0] r_dq   [0:DS];
    logic [30:0] r_dr   [0:DS];
    logic [30:0] r_dm   [0:DS];
    logic        r_dneg [0:DS];
    logic [31:0] w_dt   [1:DS];
    logic [31:0] w_dsub [1:DS];
    logic        w_dge  [1:DS];

    always_comb begin
        for (int j = 1; j <= DS; j++) begin
            w_dt[j]   = {r_dr[j-1], r_dq[j-1][63]};
            w_dsub[j] = w_dt[j] - {1'b0, r_dm[j-1]};
            w_dge[j]  = w_dt[j] >= {1'b0, r_dm[j-1]};
        end
    end

    // pressure tail
    logic signed [63:0] r_q;
    logic signed [63:0] r_qc [1:4];
    logic signed [63:0] w_ps;
    logic [63:0]        r_ll;
    logic [31:0]        r_lh;
    logic signed [48:0] r_fl;
    logic signed [31:0] r_fh;
    logic [63:0]        r_pp;
    logic signed [63:0] w_fs, w_f;
    logic signed [63:0] r_fc [2:4];
    logic signed [48:0] r_el;
    logic signed [31:0] r_eh;
    logic signed [63:0] w_es, w_e, r_e;
    logic signed [63:0] w_p5s, w_p5sh;
    logic signed [63:0] r_pr;
    logic [31:0]        r_pres;
    logic               r_pval;

    assign w_ps  = r_q >>> 13;
    assign w_fs  = {{15{r_fl[48]}}, r_fl} + {r_fh, 32'b0};
    assign w_f   = w_fs >>> 19;
    assign w_es  = {{15{r_el[48]}}, r_el} + {r_eh, 32'b0};
    assign w_e   = w_es >>> 25;
    assign w_p5s = r_qc[4] + r_e + r_fc[4];
    assign w_p5sh = w_p5s >>> 8;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rt0   <= i_raw_temperature;
            r_rp[0] <= i_raw_pressure;
            r_rh[0] <= i_raw_humidity;
            for (int k = 1; k <= 8; k++) r_rp[k] <= r_rp[k-1];
            for (int k = 1; k <= 4; k++) r_rh[k] <= r_rh[k-1];
            for (int k = ST_TF + 1; k <= ST_OUT; k++) r_tf[k] <= r_tf[k-1];
            for (int k = ST_TEMP + 1; k <= ST_OUT; k++) r_temp[k] <= r_temp[k-1];
            for (int k = ST_DIV + 1; k <= ST_OUT; k++) r_hum[k] <= r_hum[k-1];
            for (int k = ST_DIV + 1; k <= ST_OUT - 1; k++) r_zero[k] <= r_zero[k-1];

            r_s1_x2 <= w_s1_xp[31:0];
            r_s1_dd <= w_s1_dd[31:0];
            r_s2_v1 <= r_s1_x2 >>> 11;
            r_s2_m3 <= w_s2_m[31:0];
            r_tf[ST_TF]     <= r_s2_v1 + (r_s2_m3 >>> 14) + r_fine_temp_offset;
            r_temp[ST_TEMP] <= w_s4_t5[31:8];

            r_s4_hm5 <= w_h5 * w_s4_hv;
            r_s4_hm6 <= w_s4_hv * w_h6;
            r_s4_hm3 <= w_s4_hv * $signed({1'b0, w_h3});
            r_ha[5]  <= w_s5_ha >>> 15;
            r_s5_x6  <= r_s4_hm6 >>> 10;
            r_s5_y3  <= (r_s4_hm3 >>> 11) + esc_pkg::H_BIAS_A;
            for (int k = 6; k <= 8; k++) r_ha[k] <= r_ha[k-1];
            r_s6_hb0 <= r_s5_x6 * r_s5_y3;
            r_s7_hb1 <= ((r_s6_hb0 >>> 10) + esc_pkg::H_BIAS_B) * w_h2;
            r_s8_hb  <= (r_s7_hb1 + esc_pkg::H_ROUND_B) >>> 14;
            r_vv[9]  <= r_ha[8] * r_s8_hb;
            r_vv[10] <= r_vv[9];
            r_vv[11] <= r_vv[10];
            r_s10_sq <= w_s10_s * w_s10_s;
            r_s11_k  <= (r_s10_sq >>> 7) * $signed({1'b0, w_h1});
            if (w_s12_v[31]) begin
                r_hum[ST_DIV] <= '0;
            end else if (w_s12_v > esc_pkg::H_MAX) begin
                r_hum[ST_DIV] <= esc_pkg::H_MAX[28:12];
            end else begin
                r_hum[ST_DIV] <= w_s12_v[28:12];
            end

            r_s4_a   <= {r_tf[ST_TF][31], r_tf[ST_TF]} - esc_pkg::T_FINE_BASE;
            r_s5_aa  <= w_s5_aa[63:0];
            r_ap5[5] <= r_s4_a * w_p5;
            r_ap2[5] <= r_s4_a * w_p2;
            for (int k = 6; k <= 7; k++) begin
                r_ap5[k] <= r_ap5[k-1];
                r_ap2[k] <= r_ap2[k-1];
            end
            r_s6_b6l  <= $signed({1'b0, r_s5_aa[31:0]}) * w_p6;
            r_s6_b6h  <= $signed(r_s5_aa[63:32]) * w_p6;
            r_s6_b3l  <= $signed({1'b0, r_s5_aa[31:0]}) * w_p3;
            r_s6_b3h  <= $signed(r_s5_aa[63:32]) * w_p3;
            r_s7_aap6 <= {{15{r_s6_b6l[48]}}, r_s6_b6l} + {r_s6_b6h, 32'b0};
            r_s7_aap3 <= {{15{r_s6_b3l[48]}}, r_s6_b3l} + {r_s6_b3h, 32'b0};
            r_s8_b    <= r_s7_aap6 + {r_ap5[7][46:0], 17'b0}
                         + {{13{w_p4[15]}}, w_p4, 35'b0};
            r_s8_a2   <= w_s8_a3s + {{3{r_ap2[7][48]}}, r_ap2[7], 12'b0};
            r_s9_x    <= r_s8_a2 + esc_pkg::P_ONE47;
            r_s9_n    <= {12'b0, w_s9_pd, 31'b0} - r_s8_b;
            r_s10_xl  <= r_s9_x[31:0] * w_p1;
            r_s10_xh  <= r_s9_x[63:32] * w_p1;
            r_s10_nl  <= r_s9_n[31:0] * esc_pkg::P_SCALE;
            r_s10_nh  <= r_s9_n[63:32] * esc_pkg::P_SCALE;
            r_s11_ad  <= w_s11_sx[63:33];
            r_s11_num <= {20'b0, r_s10_nl} + {r_s10_nh, 32'b0};

            r_dq[0]   <= r_s11_num[63] ? (~r_s11_num + 64'd1) : r_s11_num;
            r_dm[0]   <= r_s11_ad[30] ? (~r_s11_ad + 31'd1) : r_s11_ad;
            r_dr[0]   <= '0;
            r_dneg[0] <= r_s11_num[63] ^ r_s11_ad[30];
            r_zero[ST_DIV] <= (r_s11_ad == '0);
            for (int j = 1; j <= DS; j++) begin
                r_dq[j]   <= {r_dq[j-1][62:0], w_dge[j]};
                r_dr[j]   <= w_dge[j] ? w_dsub[j][30:0] : w_dt[j][30:0];
                r_dm[j]   <= r_dm[j-1];
                r_dneg[j] <= r_dneg[j-1];
            end

            r_q     <= r_dneg[DS] ? $signed(~r_dq[DS] + 64'd1) : $signed(r_dq[DS]);
            r_qc[1] <= r_q;
            for (int k = 2; k <= 4; k++) r_qc[k] <= r_qc[k-1];
            r_ll    <= w_ps[31:0] * w_ps[31:0];
            r_lh    <= w_ps[31:0] * w_ps[63:32];
            r_fl    <= $signed({1'b0, r_q[31:0]}) * w_p8;
            r_fh    <= $signed(r_q[63:32]) * w_p8;
            r_pp    <= r_ll + {r_lh[30:0], 1'b0, 32'b0};
            r_fc[2] <= w_f;
            r_fc[3] <= r_fc[2];
            r_fc[4] <= r_fc[3];
            r_el    <= $signed({1'b0, r_pp[31:0]}) * w_p9;
            r_eh    <= $signed(r_pp[63:32]) * w_p9;
            r_e     <= w_e;
            r_pr    <= w_p5sh + {{44{w_p7[15]}}, w_p7, 4'b0};
            if (r_zero[ST_OUT-1] || r_pr[63]) begin
                r_pres <= '0;
            end else if (r_pr[63:32] != '0) begin
                r_pres <= '1;
            end else begin
                r_pres <= r_pr[31:0];
            end
            r_pval <= !r_zero[ST_OUT-1];
        end
    end

    assign o_out_valid         = r_vld[ST_OUT];
    assign o_temperature_centi = r_temp[ST_OUT];
    assign o_pressure_q24_8    = r_pres;
    assign o_pressure_valid    = r_pval;
    assign o_humidity_q22_10   = r_hum[ST_OUT];
    assign o_fine_temp         = r_tf[ST_OUT];

    a_zero_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pressure_valid |-> o_pressure_q24_8 == '0)
        else $error("pressure not forced to zero on zero divisor");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_humidity_q22_10 <= 17'd102400)
        else $error("humidity above clamp");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");

    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_Q-1] && !r_zero[ST_Q-1] |-> r_dr[DS] < r_dm[DS])
        else $error("division remainder not below divisor");

endmodule

`default_nettype wire
